// File: src/delta_list_timer_manager_core_defines.svh
// Assertion macros for the checker file.
`ifndef DELTA_LIST_TIMER_MANAGER_CORE_DEFINES_SVH
`define DELTA_LIST_TIMER_MANAGER_CORE_DEFINES_SVH

// Antecedent implies consequent on the same edge.
`define DLT_ASSERT_IMP(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);

// Antecedent implies consequent on the next edge.
`define DLT_ASSERT_NXT(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);

`endif

// File: src/dltm_pkg.sv
package dltm_pkg;
  localparam int MaxTimers = 16;
  localparam int IdxW = $clog2(MaxTimers);
  localparam int CntW = $clog2(MaxTimers + 1);
  localparam int MaxResults = 16;
  localparam int ResCntW = $clog2(MaxResults + 1);

  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_INSTALL = 2'd1,
    CMD_DELETE  = 2'd2,
    CMD_REFRESH = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DEL_RD,
    ST_DEL_CHK,
    ST_DEL_FOLD,
    ST_DEL_SHIFT,
    ST_INS_CHK,
    ST_INS_RD,
    ST_INS_SCAN,
    ST_INS_SHIFT,
    ST_INS_FIX,
    ST_TICK_RD,
    ST_TICK_CHK,
    ST_RESULT
  } state_t;

  // Memory access request from the sequencer.
  typedef struct packed {
    logic            rd;
    logic [IdxW-1:0] rd_addr;
    logic            wr;
    logic [IdxW-1:0] wr_addr;
    logic [7:0]      wr_ident;
    logic [31:0]     wr_delta;
  } mem_req_t;
endpackage

// File: src/delta_list_timer_manager_core.sv
// Delta-list timer manager: up to 16 one-shot timers kept in a single-port
// slot memory ordered by expiry. One command item is processed at a time;
// install scans the active entries and then moves entries up, delete
// searches the entries and then moves entries down, refresh does the two
// together, and a tick examines head entries. Expired timers are reported
// one item per expiry, up to 16 per tick, with the final report held back
// until the next head has been checked so that it can carry last.
module delta_list_timer_manager_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [7:0]  in_timer_id,
  input  logic [31:0] in_timeout_ticks,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic        out_ok,
  output logic [7:0]  out_expired_id,
  output logic        out_last
);
  import dltm_pkg::*;

  mem_req_t    req;
  logic [7:0]  rd_ident;
  logic [31:0] rd_delta;

  dltm_seq u_seq (
    .clk, .rst_n, .in_valid, .in_stall, .in_cmd, .in_timer_id, .in_timeout_ticks,
    .out_valid, .out_stall, .out_kind, .out_ok, .out_expired_id, .out_last,
    .req, .rd_ident, .rd_delta
  );

  dltm_slot_mem u_mem (
    .clk, .req, .rd_ident, .rd_delta
  );
endmodule

// File: src/dltm_slot_mem.sv
module dltm_slot_mem (
  input  logic              clk,
  input  dltm_pkg::mem_req_t req,
  output logic [7:0]        rd_ident,
  output logic [31:0]       rd_delta
);
  import dltm_pkg::*;

  logic [39:0] mem [MaxTimers];
  logic [39:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr) begin
      mem[req.wr_addr] <= {req.wr_ident, req.wr_delta};
    end
    if (req.rd) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_ident = rd_data_r[39:32];
  assign rd_delta = rd_data_r[31:0];
endmodule

// File: src/dltm_seq.sv
module dltm_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_cmd,
  input  logic [7:0]         in_timer_id,
  input  logic [31:0]        in_timeout_ticks,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_kind,
  output logic               out_ok,
  output logic [7:0]         out_expired_id,
  output logic               out_last,
  output dltm_pkg::mem_req_t req,
  input  logic [7:0]         rd_ident,
  input  logic [31:0]        rd_delta
);
  import dltm_pkg::*;

  state_t           state_r, state_nxt;
  logic [CntW-1:0]  count_r, count_nxt;
  logic [CntW-1:0]  first_r, first_nxt;
  logic [CntW-1:0]  ptr_r, ptr_nxt;
  logic [CntW-1:0]  pos_r, pos_nxt;
  logic [1:0]       cmd_r, cmd_nxt;
  logic [7:0]       id_r, id_nxt;
  logic [31:0]      ticks_r, ticks_nxt;
  logic [32:0]      sum_r, sum_nxt;
  logic [32:0]      prefix_r, prefix_nxt;
  logic [31:0]      carry_r, carry_nxt;
  logic [7:0]       cid_r, cid_nxt;
  logic [ResCntW-1:0] nres_r, nres_nxt;
  logic             ov_r, ov_nxt;
  logic             ok_r, ok_nxt;
  logic             st_ok_r, st_ok_nxt;
  logic             kind_r, kind_nxt;
  logic [7:0]       eid_r, eid_nxt;
  logic             last_r, last_nxt;
  logic [32:0]      sum_add;
  logic [31:0]      nd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      first_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      first_r <= first_nxt;
      ov_r    <= ov_nxt;
    end
    ptr_r <= ptr_nxt; pos_r <= pos_nxt; cmd_r <= cmd_nxt; id_r <= id_nxt;
    ticks_r <= ticks_nxt; sum_r <= sum_nxt; prefix_r <= prefix_nxt;
    carry_r <= carry_nxt; cid_r <= cid_nxt; nres_r <= nres_nxt; ok_r <= ok_nxt;
    st_ok_r <= st_ok_nxt;
    kind_r <= kind_nxt; eid_r <= eid_nxt; last_r <= last_nxt;
  end

  assign in_stall       = (state_r != ST_IDLE);
  assign out_valid      = ov_r;
  assign out_kind       = kind_r;
  assign out_ok         = ok_r;
  assign out_expired_id = eid_r;
  assign out_last       = last_r;
  assign sum_add = sum_r + {1'b0, rd_delta};
  assign nd      = ticks_r - prefix_r[31:0];

  always_comb begin
    state_nxt = state_r; count_nxt = count_r; first_nxt = first_r;
    ptr_nxt = ptr_r; pos_nxt = pos_r; cmd_nxt = cmd_r; id_nxt = id_r;
    ticks_nxt = ticks_r; sum_nxt = sum_r; prefix_nxt = prefix_r;
    carry_nxt = carry_r; cid_nxt = cid_r; nres_nxt = nres_r; ok_nxt = ok_r;
    st_ok_nxt = st_ok_r;
    kind_nxt = kind_r; eid_nxt = eid_r; last_nxt = last_r;
    ov_nxt = ov_r && out_stall;
    req = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd_nxt = in_cmd;
          id_nxt = in_timer_id;
          ticks_nxt = (in_timeout_ticks == 32'd0) ? 32'd1 : in_timeout_ticks;
          ptr_nxt = '0;
          nres_nxt = '0;
          case (cmd_t'(in_cmd))
            CMD_TICK: begin
              ptr_nxt = first_r;
              state_nxt = (first_r < count_r) ? ST_TICK_RD : ST_IDLE;
            end
            CMD_INSTALL: state_nxt = ST_INS_CHK;
            default: state_nxt = ST_DEL_RD;
          endcase
        end
      end
      ST_DEL_RD: begin
        if (ptr_r >= count_r) begin
          st_ok_nxt = 1'b0;
          state_nxt = ST_RESULT;
        end else begin
          req.rd = 1'b1;
          req.rd_addr = ptr_r[IdxW-1:0];
          state_nxt = ST_DEL_CHK;
        end
      end
      ST_DEL_CHK: begin
        if (rd_ident == id_r) begin
          carry_nxt = rd_delta;
          pos_nxt = ptr_r;
          if (ptr_r < first_r) first_nxt = first_r - 1'b1;
          ptr_nxt = ptr_r + 1'b1;
          state_nxt = ST_DEL_FOLD;
        end else begin
          ptr_nxt = ptr_r + 1'b1;
          state_nxt = ST_DEL_RD;
        end
      end
      ST_DEL_FOLD: begin
        // ptr_r is the next entry above the removed one; it moves down one slot.
        if (ptr_r >= count_r) begin
          count_nxt = count_r - 1'b1;
          if (cmd_r == CMD_REFRESH) begin
            state_nxt = ST_INS_CHK;
          end else begin
            st_ok_nxt = 1'b1;
            state_nxt = ST_RESULT;
          end
        end else begin
          req.rd = 1'b1;
          req.rd_addr = ptr_r[IdxW-1:0];
          state_nxt = ST_DEL_SHIFT;
        end
      end
      ST_DEL_SHIFT: begin
        req.wr = 1'b1;
        req.wr_addr = ptr_r[IdxW-1:0] - 1'b1;
        req.wr_ident = rd_ident;
        req.wr_delta = rd_delta + carry_r;
        carry_nxt = '0;
        ptr_nxt = ptr_r + 1'b1;
        state_nxt = ST_DEL_FOLD;
      end
      ST_INS_CHK: begin
        if (count_r >= CntW'(MaxTimers)) begin
          st_ok_nxt = 1'b0;
          state_nxt = ST_RESULT;
        end else begin
          sum_nxt = '0;
          prefix_nxt = '0;
          ptr_nxt = first_r;
          pos_nxt = count_r;
          state_nxt = ST_INS_RD;
        end
      end
      ST_INS_RD: begin
        if (ptr_r >= count_r) begin
          ptr_nxt = count_r;
          state_nxt = ST_INS_SHIFT;
        end else begin
          req.rd = 1'b1;
          req.rd_addr = ptr_r[IdxW-1:0];
          state_nxt = ST_INS_SCAN;
        end
      end
      ST_INS_SCAN: begin
        sum_nxt = sum_add;
        if (sum_add > {1'b0, ticks_r}) begin
          pos_nxt = ptr_r;
          ptr_nxt = count_r;
          state_nxt = ST_INS_SHIFT;
        end else begin
          prefix_nxt = sum_add;
          ptr_nxt = ptr_r + 1'b1;
          state_nxt = ST_INS_RD;
        end
      end
      ST_INS_SHIFT: begin
        // Moves entries up from the top, one read and one write per step, then writes the new entry.
        if (ptr_r > pos_r) begin
          req.rd = 1'b1;
          req.rd_addr = ptr_r[IdxW-1:0] - 1'b1;
          state_nxt = ST_INS_FIX;
        end else begin
          req.wr = 1'b1;
          req.wr_addr = pos_r[IdxW-1:0];
          req.wr_ident = id_r;
          req.wr_delta = nd;
          count_nxt = count_r + 1'b1;
          st_ok_nxt = 1'b1;
          state_nxt = ST_RESULT;
        end
      end
      ST_INS_FIX: begin
        req.wr = 1'b1;
        req.wr_addr = ptr_r[IdxW-1:0];
        req.wr_ident = rd_ident;
        req.wr_delta = (ptr_r == pos_r + 1'b1) ? rd_delta - nd : rd_delta;
        ptr_nxt = ptr_r - 1'b1;
        state_nxt = ST_INS_SHIFT;
      end
      ST_TICK_RD: begin
        if (!ov_r || !out_stall) begin
          if (first_r >= count_r) begin
            state_nxt = ST_IDLE;
          end else begin
            req.rd = 1'b1;
            req.rd_addr = first_r[IdxW-1:0];
            state_nxt = ST_TICK_CHK;
          end
        end
      end
      ST_TICK_CHK: begin
        if (first_r == ptr_r && rd_delta != 32'd0 && rd_delta != 32'd1) begin
          req.wr = 1'b1;
          req.wr_addr = first_r[IdxW-1:0];
          req.wr_ident = rd_ident;
          req.wr_delta = rd_delta - 1'b1;
          state_nxt = ST_IDLE;
        end else if (first_r != ptr_r && rd_delta != 32'd0) begin
          state_nxt = ST_IDLE;
        end else begin
          if (first_r == ptr_r) begin
            req.wr = 1'b1;
            req.wr_addr = first_r[IdxW-1:0];
            req.wr_ident = rd_ident;
            req.wr_delta = '0;
          end
          first_nxt = first_r + 1'b1;
          if (nres_r < ResCntW'(MaxResults)) begin
            // Report is held one step so last can be known from the next head.
            if (nres_r != '0) ov_nxt = 1'b1;
            kind_nxt = 1'b1; ok_nxt = 1'b1; eid_nxt = cid_r;
            last_nxt = 1'b0;
            nres_nxt = nres_r + 1'b1;
            cid_nxt = rd_ident;
          end
          ptr_nxt = '1;
          state_nxt = ST_TICK_RD;
        end
        if (state_nxt == ST_IDLE && nres_r != '0) begin
          ov_nxt = 1'b1;
          last_nxt = 1'b1;
          kind_nxt = 1'b1; ok_nxt = 1'b1; eid_nxt = cid_r;
        end
      end
      ST_RESULT: begin
        if (!ov_r || !out_stall) begin
          ov_nxt = 1'b1;
          kind_nxt = 1'b0;
          ok_nxt = st_ok_r;
          eid_nxt = '0;
          last_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (state_r == ST_TICK_CHK && state_nxt == ST_TICK_RD && nres_r == '0) begin
      ov_nxt = ov_r && out_stall;
    end
    if (state_r == ST_TICK_RD && state_nxt == ST_IDLE && nres_r != '0) begin
      ov_nxt = 1'b1;
      last_nxt = 1'b1;
      kind_nxt = 1'b1; ok_nxt = 1'b1; eid_nxt = cid_r;
    end
  end
endmodule

// File: src/dltm_checker.sv
`include "delta_list_timer_manager_core_defines.svh"

module dltm_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_kind,
  input logic       out_ok,
  input logic [7:0] out_expired_id,
  input logic       out_last
);
  `DLT_ASSERT_IMP(a_status_last, out_valid && !out_kind, out_last, "status item without last")
  `DLT_ASSERT_IMP(a_status_id, out_valid && !out_kind, out_expired_id == 8'd0, "status id set")
  `DLT_ASSERT_IMP(a_report_ok, out_valid && out_kind, out_ok, "report without ok")
  `DLT_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_kind) && $stable(out_ok) && $stable(out_expired_id) && $stable(out_last), "stalled result changed")
endmodule

bind delta_list_timer_manager_core dltm_checker u_chk (
  .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .out_kind, .out_ok,
  .out_expired_id, .out_last
);

// File: tb/tb_delta_list_timer_manager_core.sv
`timescale 1ns / 100ps

import dltm_pkg::*;

typedef struct packed {
  bit       kind;
  bit       ok;
  bit [7:0] expired_id;
  bit       last;
} timer_result_t;

class timer_scoreboard;
  bit [7:0]      ident[MaxTimers];
  bit [31:0]     delta[MaxTimers];
  int            count;
  int            active;
  timer_result_t pending[$];
  int            errors;

  function new();
    count = 0;
    active = 0;
    errors = 0;
  endfunction

  function bit insert_timer(bit [7:0] id, bit [31:0] ticks);
    longint unsigned sum;
    longint unsigned prefix;
    int pos;
    bit [31:0] nd;
    sum = 0;
    prefix = 0;
    pos = count;
    if (count >= MaxTimers) return 0;
    if (ticks == 0) ticks = 1;
    for (int n = active; n < count; n++) begin
      sum += delta[n];
      if (sum > ticks) begin
        pos = n;
        break;
      end
      prefix = sum;
    end
    for (int n = count; n > pos; n--) begin
      ident[n] = ident[n-1];
      delta[n] = delta[n-1];
    end
    nd = ticks - prefix[31:0];
    ident[pos] = id;
    delta[pos] = nd;
    count++;
    if (pos + 1 < count) delta[pos+1] = delta[pos+1] - nd;
    return 1;
  endfunction

  function bit remove_timer(bit [7:0] id);
    int n;
    for (n = 0; n < count; n++)
      if (ident[n] == id) break;
    if (n >= count) return 0;
    if (n + 1 < count) delta[n+1] = delta[n+1] + delta[n];
    for (int i = n; i + 1 < count; i++) begin
      ident[i] = ident[i+1];
      delta[i] = delta[i+1];
    end
    count--;
    if (n < active) active--;
    return 1;
  endfunction

  function void note_item(cmd_t cmd, bit [7:0] id, bit [31:0] ticks);
    timer_result_t r;
    int k;
    bit ok;
    k = 0;
    r.kind = 0;
    r.ok = 0;
    r.expired_id = 0;
    r.last = 0;
    if (cmd == CMD_TICK) begin
      if (active >= count) return;
      if (delta[active] != 0) delta[active]--;
      while (active < count && delta[active] == 0) begin
        if (k < MaxResults) begin
          r.kind = 1;
          r.ok = 1;
          r.expired_id = ident[active];
          r.last = 0;
          pending.push_back(r);
          k++;
        end
        active++;
      end
      if (k > 0) pending[pending.size()-1].last = 1;
      return;
    end
    if (cmd == CMD_INSTALL) ok = insert_timer(id, ticks);
    else begin
      ok = remove_timer(id);
      if (ok && cmd == CMD_REFRESH) ok = insert_timer(id, ticks);
    end
    r.ok = ok;
    r.last = 1;
    pending.push_back(r);
  endfunction

  function void check_result(timer_result_t got);
    timer_result_t want;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result kind=%0b ok=%0b id=%0d last=%0b", $time,
               got.kind, got.ok, got.expired_id, got.last);
      errors++;
      return;
    end
    want = pending.pop_front();
    if (want != got) begin
      $display("%0t: expected kind=%0b ok=%0b id=%0d last=%0b, got kind=%0b ok=%0b id=%0d last=%0b",
               $time, want.kind, want.ok, want.expired_id, want.last,
               got.kind, got.ok, got.expired_id, got.last);
      errors++;
    end
  endfunction
endclass

module tb_delta_list_timer_manager_core;
  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [1:0]  in_cmd = 0;
  logic [7:0]  in_timer_id = 0;
  logic [31:0] in_timeout_ticks = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic        out_kind;
  logic        out_ok;
  logic [7:0]  out_expired_id;
  logic        out_last;

  timer_scoreboard board = new();
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  hold_off = 0;
  int  quiet_cycles = 0;
  bit  [7:0] used_ids[$];

  delta_list_timer_manager_core DUT (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      timer_result_t got;
      got.kind = out_kind;
      got.ok = out_ok;
      got.expired_id = out_expired_id;
      got.last = out_last;
      board.check_result(got);
    end
    if (rst_n && in_valid && !in_stall)
      board.note_item(cmd_t'(in_cmd), in_timer_id, in_timeout_ticks);
  end

  // Receiver stall, decided once per cycle.
  always @(posedge clk)
    out_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);

  // Watchdog: cycles without any handshake.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Valid stays high after an accepted item only when the next item follows at once.
  task automatic send_item(cmd_t cmd, bit [7:0] id, bit [31:0] ticks);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_cmd <= cmd;
    in_timer_id <= id;
    in_timeout_ticks <= ticks;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Mostly small timeouts and a small ID pool so that deletes hit and ticks expire.
  task automatic send_random();
    int sel;
    bit [7:0] id;
    bit [31:0] ticks;
    sel = $urandom_range(99);
    id = 8'($urandom_range(9));
    if ($urandom_range(9) == 0) id = 8'($urandom);
    case ($urandom_range(9))
      0: ticks = $urandom;
      1: ticks = 0;
      default: ticks = $urandom_range(6);
    endcase
    if (sel < 45) send_item(CMD_TICK, id, ticks);
    else if (sel < 75) send_item(CMD_INSTALL, id, ticks);
    else if (sel < 88) send_item(CMD_DELETE, id, ticks);
    else send_item(CMD_REFRESH, id, ticks);
  endtask

  task automatic drain();
    while (board.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: empty tick, misses, extremes, equal timeouts, zero timeout.
    send_item(CMD_TICK, 8'h00, 0);
    send_item(CMD_DELETE, 8'h11, 0);
    send_item(CMD_REFRESH, 8'h11, 5);
    send_item(CMD_INSTALL, 8'hFF, 32'hFFFF_FFFF);
    send_item(CMD_INSTALL, 8'h00, 0);
    send_item(CMD_INSTALL, 8'h01, 2);
    send_item(CMD_INSTALL, 8'h02, 2);
    send_item(CMD_INSTALL, 8'hAA, 32'h5555_5555);
    send_item(CMD_TICK, 8'hFF, 32'hFFFF_FFFF);
    send_item(CMD_REFRESH, 8'h01, 1);
    send_item(CMD_TICK, 8'h00, 0);
    send_item(CMD_DELETE, 8'h00, 0);
    send_item(CMD_DELETE, 8'hFF, 0);
    send_item(CMD_DELETE, 8'hAA, 0);
    send_item(CMD_DELETE, 8'h02, 0);
    send_item(CMD_DELETE, 8'h01, 0);
    // Fill the table, overflow it, then expire everything on one tick.
    for (int i = 0; i < 17; i++) send_item(CMD_INSTALL, 8'(i + 40), 1);
    send_item(CMD_TICK, 8'h00, 0);
    send_item(CMD_INSTALL, 8'h77, 3);
    for (int i = 0; i < 16; i++) send_item(CMD_DELETE, 8'(i + 40), 0);
    send_item(CMD_DELETE, 8'h77, 0);
    in_valid <= 0;
    drain();

    // Long receiver hold-off while items keep coming.
    fork
      begin
        hold_off = 1;
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
      begin
        for (int i = 0; i < 12; i++) send_random();
        in_valid <= 0;
      end
    join
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = (phase == 1 || phase == 3) ? (phase == 3 ? 24 : 73) : 0;
      recv_stall_pct = (phase == 2 || phase == 3) ? (phase == 3 ? 24 : 73) : 0;
      for (int i = 0; i < 14; i++) send_random();
      in_valid <= 0;
      drain();
    end

    if (board.errors == 0 && board.pending.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end
endmodule
